FILE: sv/fpbp_pkg.sv
// ----------------------------------------------------------------------------
// fpbp_pkg
// Shared types and constants for the fixed pattern byte patcher.
// ----------------------------------------------------------------------------
package fpbp_pkg;

  localparam int WinLen    = 6;
  localparam int CountBits = 16;
  localparam int FillBits  = 3;
  localparam int SuppBits  = 3;
  localparam int OutCntBits = 16;

  typedef logic [7:0]                byte_t;
  typedef logic [WinLen-1:0][7:0]    window_t;
  typedef logic [FillBits-1:0]       fill_t;
  typedef logic [CountBits-1:0]      count_t;
  typedef logic [OutCntBits-1:0]     out_count_t;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CfgHashEn     = 2'd0;
  localparam cfg_idx_t CfgIdentifyEn = 2'd1;
  localparam cfg_idx_t CfgPermsEn    = 2'd2;

  // byte 0 of each sequence sits at index 0
  localparam logic [3:0][7:0] HashSeqA  = {8'h0B, 8'h4B, 8'h07, 8'h20};
  localparam logic [3:0][7:0] HashSeqB  = {8'hA2, 8'h23, 8'h07, 8'h20};
  localparam logic [3:0][7:0] IdentSeq  = {8'h23, 8'hD1, 8'h03, 8'h28};
  localparam logic [5:0][7:0] PermsSeq  = {8'h66, 8'h25, 8'h01, 8'hD0, 8'h8B, 8'h42};
  localparam byte_t           PermsNew  = 8'hE0;

  localparam logic [SuppBits-1:0] SuppShort = 3'd3;
  localparam logic [SuppBits-1:0] SuppLong  = 3'd5;

  typedef struct packed {
    logic clear;
    logic set_e0;
  } patch_t;

  typedef struct packed {
    logic hash;
    logic identify;
    logic perms;
  } enables_t;

  function automatic count_t sat_inc(count_t c);
    return (c == '1) ? c : c + count_t'(1);
  endfunction

  function automatic out_count_t clamp_out(count_t c);
    logic [32:0] wide;
    wide = 33'(c);
    return (wide > 33'h0FFFF) ? '1 : wide[OutCntBits-1:0];
  endfunction

endpackage

FILE: sv/fpbp_if.sv
// ----------------------------------------------------------------------------
// fpbp_in_if / fpbp_out_if
// Valid/ready channels for input bytes and patched result bytes.
// ----------------------------------------------------------------------------
interface fpbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fpbp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [15:0] hash_matches;
  logic [15:0] identify_matches;
  logic [15:0] perms_matches;

  modport source (output valid, output out_byte, output out_last, output hash_matches,
                  output identify_matches, output perms_matches, input ready);
  modport sink   (input valid, input out_byte, input out_last, input hash_matches,
                  input identify_matches, input perms_matches, output ready);
endinterface

FILE: sv/fpbp_cell.sv
// ----------------------------------------------------------------------------
// fpbp_cell
// One window slot: holds a byte, applies its patch and hands it to its
// neighbor toward the head on a shift.
// ----------------------------------------------------------------------------
module fpbp_cell (
  input  logic           clk_i,
  input  fpbp_pkg::byte_t  in_byte_i,
  input  logic           sel_in_i,
  input  logic           shift_i,
  input  fpbp_pkg::byte_t  nb_fwd_i,
  input  fpbp_pkg::patch_t patch_i,
  output fpbp_pkg::byte_t  view_o,
  output fpbp_pkg::byte_t  fwd_o
);
  import fpbp_pkg::*;

  byte_t byte_q, byte_d;

  // the incoming byte is visible in its slot in the same cycle
  assign view_o = sel_in_i ? in_byte_i : byte_q;

  always_comb begin
    fwd_o = view_o;
    if (patch_i.clear) begin
      fwd_o = '0;
    end else if (patch_i.set_e0) begin
      fwd_o = PermsNew;
    end
  end

  always_comb begin
    byte_d = byte_q;
    if (shift_i) begin
      byte_d = nb_fwd_i;
    end else if (sel_in_i) begin
      byte_d = in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

FILE: sv/fpbp_matcher.sv
// ----------------------------------------------------------------------------
// fpbp_matcher
// Head test: compares the window with the three sequences, issues patches,
// keeps the suppress counter and the saturating match counts.
// ----------------------------------------------------------------------------
module fpbp_matcher (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fpbp_pkg::window_t    view_i,
  input  fpbp_pkg::fill_t      avail_i,
  input  logic                 test_i,
  input  logic                 done_i,
  input  fpbp_pkg::enables_t   en_i,
  output fpbp_pkg::patch_t     patch_o [fpbp_pkg::WinLen],
  output fpbp_pkg::count_t     hash_cnt_o,
  output fpbp_pkg::count_t     ident_cnt_o,
  output fpbp_pkg::count_t     perms_cnt_o
);
  import fpbp_pkg::*;

  logic [SuppBits-1:0] supp_q, supp_d;
  count_t hash_q, hash_d, ident_q, ident_d, perms_q, perms_d;
  logic   hash_hit, ident_hit, perms_hit;

  assign hash_hit  = en_i.hash && (avail_i >= fill_t'(4)) &&
                     ((view_i[3:0] == HashSeqA) || (view_i[3:0] == HashSeqB));
  assign ident_hit = en_i.identify && (avail_i >= fill_t'(4)) && (view_i[3:0] == IdentSeq);
  assign perms_hit = en_i.perms && (avail_i >= fill_t'(6)) && (view_i == PermsSeq);

  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      patch_o[i] = '0;
    end
    supp_d  = supp_q;
    hash_d  = hash_q;
    ident_d = ident_q;
    perms_d = perms_q;
    if (test_i) begin
      if (supp_q != '0) begin
        supp_d = supp_q - 1'b1;
      end else if (hash_hit) begin
        patch_o[1].clear = 1'b1;
        hash_d = sat_inc(hash_q);
        supp_d = SuppShort;
      end else if (ident_hit) begin
        patch_o[2].clear = 1'b1;
        patch_o[3].clear = 1'b1;
        ident_d = sat_inc(ident_q);
        supp_d = SuppShort;
      end else if (perms_hit) begin
        patch_o[2].set_e0 = 1'b1;
        perms_d = sat_inc(perms_q);
        supp_d = SuppLong;
      end
    end
    // end of buffer: counts and suppression start over
    if (done_i) begin
      supp_d  = '0;
      hash_d  = '0;
      ident_d = '0;
      perms_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supp_q  <= '0;
      hash_q  <= '0;
      ident_q <= '0;
      perms_q <= '0;
    end else begin
      supp_q  <= supp_d;
      hash_q  <= hash_d;
      ident_q <= ident_d;
      perms_q <= perms_d;
    end
  end

  assign hash_cnt_o  = hash_q;
  assign ident_cnt_o = ident_q;
  assign perms_cnt_o = perms_q;

endmodule

FILE: sv/fixed_pattern_byte_patcher.sv
// ----------------------------------------------------------------------------
// fixed_pattern_byte_patcher
// Streaming byte patcher with a six-byte window built from a row of cells.
// ----------------------------------------------------------------------------
// Bytes stream in at one per cycle unless the output stalls or a flush runs,
// and leave five positions later through a single output register; the head
// is tested against the enabled sequences, unless suppressed, in the cycle
// it leaves. A byte marked last starts a flush: input ready drops while the
// window drains one byte per cycle as the output accepts them. Match counts
// appear only on the final output byte and restart at zero for the next
// buffer. Enables must be written while idle; the block does not check it.
module fixed_pattern_byte_patcher (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fpbp_in_if.sink              in_chan_i,
  fpbp_out_if.source           out_chan_o,
  input  logic                 cfg_we_i,
  input  fpbp_pkg::cfg_idx_t   cfg_idx_i,
  input  logic                 cfg_data_i
);
  import fpbp_pkg::*;

  enables_t en_q, en_d;
  fill_t    fill_q, fill_d;
  logic     flush_q, flush_d;

  logic       out_valid_q, out_valid_d;
  byte_t      out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  out_count_t hash_out_q, hash_out_d, ident_out_q, ident_out_d, perms_out_q, perms_out_d;

  logic    can_emit, in_ready, acc, norm_emit, flush_emit, emit, fin;
  fill_t   avail;
  window_t view;
  byte_t   fwd [WinLen];
  patch_t  patch [WinLen];
  count_t  hash_cnt, ident_cnt, perms_cnt;

  assign can_emit   = !out_valid_q || out_chan_o.ready;
  assign in_ready   = !flush_q && ((fill_q < fill_t'(WinLen - 1)) || can_emit);
  assign acc        = in_chan_i.valid && in_ready;
  assign norm_emit  = acc && !in_chan_i.last_byte && (fill_q == fill_t'(WinLen - 1));
  assign flush_emit = flush_q && can_emit;
  assign emit       = norm_emit || flush_emit;
  assign fin        = flush_emit && (fill_q == fill_t'(1));
  assign avail      = flush_q ? fill_q : fill_t'(WinLen);

  assign in_chan_i.ready = in_ready;

  for (genvar i = 0; i < WinLen; i++) begin : g_cell
    byte_t nb;
    if (i == WinLen - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_mid
      assign nb = fwd[i+1];
    end
    fpbp_cell u_cell (
      .clk_i     (clk_i),
      .in_byte_i (in_chan_i.data_byte),
      .sel_in_i  (acc && (fill_q == fill_t'(i))),
      .shift_i   (emit),
      .nb_fwd_i  (nb),
      .patch_i   (patch[i]),
      .view_o    (view[i]),
      .fwd_o     (fwd[i])
    );
  end

  fpbp_matcher u_matcher (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .view_i      (view),
    .avail_i     (avail),
    .test_i      (emit),
    .done_i      (fin),
    .en_i        (en_q),
    .patch_o     (patch),
    .hash_cnt_o  (hash_cnt),
    .ident_cnt_o (ident_cnt),
    .perms_cnt_o (perms_cnt)
  );

  always_comb begin
    en_d = en_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHashEn:     en_d.hash     = cfg_data_i;
        CfgIdentifyEn: en_d.identify = cfg_data_i;
        CfgPermsEn:    en_d.perms    = cfg_data_i;
        default:       en_d = en_q;
      endcase
    end
  end

  always_comb begin
    fill_d  = fill_q;
    flush_d = flush_q;
    if (acc && !norm_emit) begin
      fill_d = fill_q + fill_t'(1);
    end else if (flush_emit) begin
      fill_d = fill_q - fill_t'(1);
    end
    if (acc && in_chan_i.last_byte) begin
      flush_d = 1'b1;
    end else if (fin) begin
      flush_d = 1'b0;
    end
  end

  // output register, counts shown only with the final byte
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    hash_out_d  = hash_out_q;
    ident_out_d = ident_out_q;
    perms_out_d = perms_out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = view[0];
      out_last_d  = fin;
      hash_out_d  = fin ? clamp_out(hash_cnt)  : '0;
      ident_out_d = fin ? clamp_out(ident_cnt) : '0;
      perms_out_d = fin ? clamp_out(perms_cnt) : '0;
    end else if (out_chan_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= '0;
      fill_q      <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      en_q        <= en_d;
      fill_q      <= fill_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    hash_out_q  <= hash_out_d;
    ident_out_q <= ident_out_d;
    perms_out_q <= perms_out_d;
  end

  assign out_chan_o.valid            = out_valid_q;
  assign out_chan_o.out_byte         = out_byte_q;
  assign out_chan_o.out_last         = out_last_q;
  assign out_chan_o.hash_matches     = hash_out_q;
  assign out_chan_o.identify_matches = ident_out_q;
  assign out_chan_o.perms_matches    = perms_out_q;

endmodule

FILE: sim/fixed_pattern_byte_patcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_pattern_byte_patcher_tb
// Streams byte buffers through the patcher with random gaps on both channels.
// A built-in window predictor patches each accepted byte and queues the bytes
// that should leave; every output transfer is compared field by field with the
// oldest queued byte. Enables change only between buffers.
// ----------------------------------------------------------------------------
module fixed_pattern_byte_patcher_tb;
  import fpbp_pkg::*;

  localparam cfg_idx_t CfgSpareIdx = 2'd3;
  localparam int DrainCycles = 8;
  localparam int RandomItems = 480;

  typedef struct packed {
    byte_t      data;
    logic       last;
    out_count_t hash;
    out_count_t identify;
    out_count_t perms;
  } patched_t;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we;
  cfg_idx_t cfg_idx;
  logic     cfg_data;

  fpbp_in_if  in_chan ();
  fpbp_out_if out_chan ();

  fixed_pattern_byte_patcher uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predictor state
  byte_t    win_model [WinLen];
  int       win_fill;
  int       skip_left;
  count_t   hash_cnt;
  count_t   ident_cnt;
  count_t   perms_cnt;
  enables_t enables;

  patched_t patched_bytes_q [$];
  int       errors;
  bit       tx_quiet;
  bit       rx_quiet;

  function automatic count_t bump(count_t c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic bit head_is(logic [5:0][7:0] seq, int len, int avail);
    if (len > avail) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (win_model[k] != seq[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void test_head(int avail);
    if (skip_left > 0) begin
      skip_left--;
      return;
    end
    if (enables.hash && (head_is({16'h0, HashSeqA}, 4, avail) ||
                         head_is({16'h0, HashSeqB}, 4, avail))) begin
      win_model[1] = 8'h00;
      hash_cnt = bump(hash_cnt);
      skip_left = SuppShort;
    end else if (enables.identify && head_is({16'h0, IdentSeq}, 4, avail)) begin
      win_model[2] = 8'h00;
      win_model[3] = 8'h00;
      ident_cnt = bump(ident_cnt);
      skip_left = SuppShort;
    end else if (enables.perms && head_is(PermsSeq, 6, avail)) begin
      win_model[2] = PermsNew;
      perms_cnt = bump(perms_cnt);
      skip_left = SuppLong;
    end
  endfunction

  function automatic void pop_head(bit fin);
    patched_t r;
    r.data     = win_model[0];
    r.last     = fin;
    r.hash     = fin ? clamp_out(hash_cnt) : '0;
    r.identify = fin ? clamp_out(ident_cnt) : '0;
    r.perms    = fin ? clamp_out(perms_cnt) : '0;
    patched_bytes_q.push_back(r);
    for (int k = 0; k < WinLen - 1; k++) win_model[k] = win_model[k+1];
    win_model[WinLen-1] = 8'h00;
    if (win_fill > 0) win_fill--;
  endfunction

  function automatic void clear_window();
    foreach (win_model[k]) win_model[k] = 8'h00;
    win_fill  = 0;
    skip_left = 0;
    hash_cnt  = '0;
    ident_cnt = '0;
    perms_cnt = '0;
  endfunction

  function automatic void predict_patched_bytes(byte_t data, logic last);
    win_model[win_fill] = data;
    win_fill++;
    if (!last) begin
      if (win_fill >= WinLen) begin
        test_head(WinLen);
        pop_head(1'b0);
      end
    end else begin
      // flush the whole window, the final byte carries the counts
      while (win_fill > 0) begin
        bit fin;
        fin = (win_fill == 1);
        test_head(win_fill);
        pop_head(fin);
      end
      clear_window();
    end
  endfunction

  task automatic send_byte(input byte_t data, input logic last);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= data;
    in_chan.last_byte <= last;
    do @(posedge clk_i); while (!in_chan.ready);
    predict_patched_bytes(data, last);
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (patched_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_buffer(input byte_t stream [$]);
    foreach (stream[k]) send_byte(stream[k], k == stream.size() - 1);
    wait_idle();
  endtask

  // one register per cycle, the spare index must be ignored
  task automatic set_enables(input enables_t e);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgHashEn;
    cfg_data <= e.hash;
    @(posedge clk_i);
    cfg_idx  <= CfgIdentifyEn;
    cfg_data <= e.identify;
    @(posedge clk_i);
    cfg_idx  <= CfgPermsEn;
    cfg_data <= e.perms;
    @(posedge clk_i);
    cfg_idx  <= CfgSpareIdx;
    cfg_data <= 1'($urandom);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    enables = e;
  endtask

  task automatic test_disabled_patterns();
    byte_t stream [$];
    set_enables(3'b000);
    stream = '{8'h20, 8'h07, 8'h4B, 8'h0B, 8'h00, 8'hFF};
    send_buffer(stream);
  endtask

  task automatic test_back_to_back_patterns();
    byte_t stream [$];
    set_enables(3'b111);
    // hash a, hash b, identify, then perms ending on the final byte
    stream = '{8'h20, 8'h07, 8'h4B, 8'h0B, 8'h20, 8'h07, 8'h23, 8'hA2,
               8'h28, 8'h03, 8'hD1, 8'h23,
               8'h42, 8'h8B, 8'hD0, 8'h01, 8'h25, 8'h66};
    send_buffer(stream);
  endtask

  task automatic test_short_tail();
    byte_t stream [$];
    stream = '{8'h28, 8'h03, 8'hD1};
    send_buffer(stream);
  endtask

  task automatic append_pattern(ref byte_t stream [$]);
    logic [5:0][7:0] seq;
    int              len;
    len = 4;
    case ($urandom_range(0, 4))
      0: seq = {16'h0, HashSeqA};
      1: seq = {16'h0, HashSeqB};
      2: seq = {16'h0, IdentSeq};
      3: begin
        seq = PermsSeq;
        len = 6;
      end
      default: begin
        seq = {PermsSeq[5:3], PermsNew, PermsSeq[1:0]};
        len = 6;
      end
    endcase
    // broken sequence: one flipped bit
    if ($urandom_range(0, 3) == 0) seq[$urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
    for (int k = 0; k < len; k++) stream.push_back(seq[k]);
  endtask

  task automatic test_random_buffers();
    byte_t       stream [$];
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    enables_t    e;
    sent = 0;
    while (sent < RandomItems) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) e = 3'b000;
      else if (pick == 1) e = 3'b111;
      else e = 3'($urandom);
      set_enables(e);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 20);
      stream.delete();
      while (stream.size() < len) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) append_pattern(stream);
        else if (pick == 5) stream.push_back(HashSeqA[0]);
        else if (pick == 6) stream.push_back(IdentSeq[0]);
        else if (pick == 7) stream.push_back(PermsSeq[0]);
        else stream.push_back(8'($urandom));
      end
      while (stream.size() > len) void'(stream.pop_back());
      send_buffer(stream);
      sent += len;
    end
  endtask

  // output side: random stalls and the per-transfer comparison
  initial begin
    int unsigned stall;
    patched_t    exp;
    out_chan.ready <= 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_chan.valid && out_chan.ready) begin
        if (patched_bytes_q.size() == 0) begin
          $error("unexpected transfer: out_byte %h", out_chan.out_byte);
          errors++;
        end else begin
          exp = patched_bytes_q.pop_front();
          if (out_chan.out_byte !== exp.data) begin
            $error("out_byte: expected %h, got %h", exp.data, out_chan.out_byte);
            errors++;
          end
          if (out_chan.out_last !== exp.last) begin
            $error("out_last: expected %b, got %b", exp.last, out_chan.out_last);
            errors++;
          end
          if (out_chan.hash_matches !== exp.hash) begin
            $error("hash_matches: expected %0d, got %0d", exp.hash, out_chan.hash_matches);
            errors++;
          end
          if (out_chan.identify_matches !== exp.identify) begin
            $error("identify_matches: expected %0d, got %0d", exp.identify,
                   out_chan.identify_matches);
            errors++;
          end
          if (out_chan.perms_matches !== exp.perms) begin
            $error("perms_matches: expected %0d, got %0d", exp.perms, out_chan.perms_matches);
            errors++;
          end
        end
        stall = rx_quiet ? 0 : $urandom_range(0, 16);
      end else if (stall > 0) begin
        stall--;
      end
      out_chan.ready <= (stall == 0);
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    errors            = 0;
    tx_quiet          = 1'b0;
    rx_quiet          = 1'b0;
    enables           = 3'b000;
    clear_window();
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CfgHashEn;
    cfg_data          <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.data_byte <= 8'h00;
    in_chan.last_byte <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled_patterns();
    test_back_to_back_patterns();
    test_short_tail();
    test_random_buffers();

    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
